/* hdl/kars_pkg.sv */
package kars_pkg;

    // key counts of the two groups
    localparam int CMD_KEYS  = 8;
    localparam int CHAR_KEYS = 48;
    localparam int NUM_LANES = CMD_KEYS + CHAR_KEYS;
    localparam int LANE_W    = $clog2(NUM_LANES);

    localparam int TIME_W    = 32;
    localparam int KEY_W     = 6;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [TIME_W-1:0] ELAPSED_MIN = TIME_W'(1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CMD_DELAY   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CMD_RELOAD  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_DELAY  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_RELOAD = CFG_IDX_W'(3);

    localparam logic GROUP_CMD  = 1'b0;
    localparam logic GROUP_CHAR = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MOD_NORMAL = 2'd0,
        MOD_SHIFT  = 2'd1,
        MOD_CTRL   = 2'd2
    } t_mod;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ELAP,
        ST_TICK,
        ST_DRAIN
    } t_state;

    // sequencer to merge stage
    typedef struct packed {
        logic load;
        t_mod mode;
    } t_scan_ctl;

    // merge stage back to sequencer
    typedef struct packed {
        logic busy;
    } t_merge_sts;

endpackage

/* hdl/kars_lane.sv */
// One key: hold-duration counter and fire decision.
module kars_lane (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_upd,
    input  logic                             i_pressed,
    input  logic [kars_pkg::TIME_W-1:0]      i_elapsed,
    input  logic [kars_pkg::TIME_W-1:0]      i_delay,
    input  logic [kars_pkg::TIME_W-1:0]      i_reload,
    output logic                             o_fire
);

    logic [kars_pkg::TIME_W-1:0] r_cnt;
    logic [kars_pkg::TIME_W-1:0] n_cnt;
    logic [kars_pkg::TIME_W-1:0] w_base;
    logic [kars_pkg::TIME_W:0]   w_sum;
    logic                        w_over;

    // past the threshold: repeat and reload
    assign w_over = r_cnt > i_delay;
    assign w_base = w_over ? i_reload : r_cnt;
    assign w_sum  = {1'b0, w_base} + {1'b0, i_elapsed};
    assign o_fire = i_pressed && ((r_cnt == '0) || w_over);

    // saturating add, released key clears
    always_comb begin
        if (!i_pressed) begin
            n_cnt = '0;
        end else if (w_sum[kars_pkg::TIME_W]) begin
            n_cnt = '1;
        end else begin
            n_cnt = w_sum[kars_pkg::TIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_upd) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

/* hdl/kars_merge.sv */
// Walks the lane fire bits in key order; one beat per fired key, or one empty beat if none fired.
module kars_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  kars_pkg::t_scan_ctl                 i_ctl,
    input  logic [kars_pkg::NUM_LANES-1:0]      i_fire,
    output kars_pkg::t_merge_sts                o_sts,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_fired,
    output logic                                o_group,
    output logic [kars_pkg::KEY_W-1:0]          o_key,
    output logic [kars_pkg::MODE_W-1:0]         o_mode,
    output logic                                o_last
);

    logic [kars_pkg::NUM_LANES-1:0] r_fire;
    logic [kars_pkg::LANE_W-1:0]    r_idx;
    logic                           r_busy;
    kars_pkg::t_mod                 r_mode;

    logic                           r_valid;
    logic                           r_fired;
    logic                           r_group;
    logic [kars_pkg::KEY_W-1:0]     r_key;
    logic [kars_pkg::MODE_W-1:0]    r_omode;
    logic                           r_last;

    logic                           w_free;
    logic [kars_pkg::NUM_LANES-1:0] w_rest;
    logic                           w_is_cmd;

    assign w_free   = !r_valid || i_ready;
    assign w_rest   = r_fire & ~({{(kars_pkg::NUM_LANES-1){1'b0}}, 1'b1} << r_idx);
    assign w_is_cmd = r_idx < kars_pkg::LANE_W'(kars_pkg::CMD_KEYS);

    // sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_fire <= '0;
            r_mode <= kars_pkg::MOD_NORMAL;
        end else if (i_ctl.load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_fire <= i_fire;
            r_mode <= i_ctl.mode;
        end else if (r_busy) begin
            if (r_fire == '0) begin
                if (w_free) begin
                    r_busy <= 1'b0;
                end
            end else if (r_fire[r_idx]) begin
                if (w_free) begin
                    r_fire <= w_rest;
                    r_idx  <= r_idx + 1'b1;
                    if (w_rest == '0) begin
                        r_busy <= 1'b0;
                    end
                end
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (r_busy && w_free && ((r_fire == '0) || r_fire[r_idx])) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && w_free) begin
            if (r_fire == '0) begin
                // scan without events
                r_fired <= 1'b0;
                r_group <= kars_pkg::GROUP_CMD;
                r_key   <= '0;
                r_omode <= kars_pkg::MOD_NORMAL;
                r_last  <= 1'b1;
            end else if (r_fire[r_idx]) begin
                r_fired <= 1'b1;
                r_last  <= (w_rest == '0);
                if (w_is_cmd) begin
                    r_group <= kars_pkg::GROUP_CMD;
                    r_key   <= kars_pkg::KEY_W'(r_idx);
                    r_omode <= kars_pkg::MOD_NORMAL;
                end else begin
                    r_group <= kars_pkg::GROUP_CHAR;
                    r_key   <= kars_pkg::KEY_W'(r_idx - kars_pkg::LANE_W'(kars_pkg::CMD_KEYS));
                    r_omode <= r_mode;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_valid    = r_valid;
    assign o_fired    = r_fired;
    assign o_group    = r_group;
    assign o_key      = r_key;
    assign o_mode     = r_omode;
    assign o_last     = r_last;

endmodule

/* hdl/key_auto_repeat_scanner.sv */
// Keyboard auto-repeat scanner. Each input beat is one scan; every key has
// its own counter lane and all lanes update together in one cycle. The
// merge stage then walks the keys in order (command keys, then character
// keys), one key per cycle while the output is not stalled, and sends one
// output beat per fired key, or one empty beat (tuser fired bit low) when no
// key fired; tlast marks the final beat of a scan. After acceptance the
// sequencer steps through ELAP (elapsed time registered) and TICK (lanes
// update, merge stage loaded), then waits in DRAIN while the merge stage
// sweeps; a stalled output holds the sweep. Only back in IDLE is the next
// scan taken, so a scan holds the input until its sweep has ended.
module key_auto_repeat_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    // scan input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [95:0] i_s_tdata,   // now_time[31:0], cmd_pressed[39:32],
                                     // char_pressed[87:40], shift_down[88],
                                     // ctrl_down[89], zero fill
    // key events
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // key_index[5:0], mod_mode[7:6]
    output logic [1:0]  o_m_tuser,   // fired[0], key_group[1]
    output logic        o_m_tlast    // last_of_scan
);

    localparam int TW = kars_pkg::TIME_W;
    localparam int NL = kars_pkg::NUM_LANES;

    kars_pkg::t_state     r_state;
    kars_pkg::t_state     n_state;
    kars_pkg::t_scan_ctl  w_ctl;
    kars_pkg::t_merge_sts w_sts;
    logic                 w_upd;
    logic                 w_accept;

    logic [TW-1:0] r_cmd_delay;
    logic [TW-1:0] r_cmd_reload;
    logic [TW-1:0] r_char_delay;
    logic [TW-1:0] r_char_reload;

    logic [TW-1:0]  r_prev_time;
    logic [TW-1:0]  r_now;
    logic [TW-1:0]  r_elapsed;
    logic [NL-1:0]  r_pressed;
    kars_pkg::t_mod r_mode;
    kars_pkg::t_mod w_mode_in;
    logic [NL-1:0]  w_fire;

    assign w_accept = i_s_tvalid && o_s_tready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_delay   <= TW'(200);
            r_cmd_reload  <= TW'(150);
            r_char_delay  <= TW'(200);
            r_char_reload <= TW'(150);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kars_pkg::REG_CMD_DELAY:   r_cmd_delay   <= i_cfg_wdata;
                kars_pkg::REG_CMD_RELOAD:  r_cmd_reload  <= i_cfg_wdata;
                kars_pkg::REG_CHAR_DELAY:  r_char_delay  <= i_cfg_wdata;
                kars_pkg::REG_CHAR_RELOAD: r_char_reload <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // shift wins over ctrl
    always_comb begin
        if (i_s_tdata[88]) begin
            w_mode_in = kars_pkg::MOD_SHIFT;
        end else if (i_s_tdata[89]) begin
            w_mode_in = kars_pkg::MOD_CTRL;
        end else begin
            w_mode_in = kars_pkg::MOD_NORMAL;
        end
    end

    // scan capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now     <= i_s_tdata[31:0];
            r_pressed <= {i_s_tdata[40 +: kars_pkg::CHAR_KEYS],
                          i_s_tdata[32 +: kars_pkg::CMD_KEYS]};
            r_mode    <= w_mode_in;
        end
    end

    // elapsed time and timestamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time <= '0;
        end else if (r_state == kars_pkg::ST_ELAP) begin
            r_prev_time <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == kars_pkg::ST_ELAP) begin
            r_elapsed <= (r_now > r_prev_time) ? (r_now - r_prev_time)
                                               : kars_pkg::ELAPSED_MIN;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kars_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            kars_pkg::ST_IDLE:  if (i_s_tvalid) n_state = kars_pkg::ST_ELAP;
            kars_pkg::ST_ELAP:  n_state = kars_pkg::ST_TICK;
            kars_pkg::ST_TICK:  n_state = kars_pkg::ST_DRAIN;
            kars_pkg::ST_DRAIN: if (!w_sts.busy) n_state = kars_pkg::ST_IDLE;
            default:            n_state = kars_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        w_upd      = 1'b0;
        case (r_state)
            kars_pkg::ST_IDLE: o_s_tready = 1'b1;
            kars_pkg::ST_TICK: w_upd      = 1'b1;
            default: ;
        endcase
    end

    assign w_ctl.load = w_upd;
    assign w_ctl.mode = r_mode;

    // key lanes
    genvar g;
    generate
        for (g = 0; g < NL; g++) begin : g_lane
            if (g < kars_pkg::CMD_KEYS) begin : g_cmd
                kars_lane u_lane (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_upd     (w_upd),
                    .i_pressed (r_pressed[g]),
                    .i_elapsed (r_elapsed),
                    .i_delay   (r_cmd_delay),
                    .i_reload  (r_cmd_reload),
                    .o_fire    (w_fire[g])
                );
            end else begin : g_char
                kars_lane u_lane (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_upd     (w_upd),
                    .i_pressed (r_pressed[g]),
                    .i_elapsed (r_elapsed),
                    .i_delay   (r_char_delay),
                    .i_reload  (r_char_reload),
                    .o_fire    (w_fire[g])
                );
            end
        end
    endgenerate

    kars_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_fire  (w_fire),
        .o_sts   (w_sts),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_fired (o_m_tuser[0]),
        .o_group (o_m_tuser[1]),
        .o_key   (o_m_tdata[5:0]),
        .o_mode  (o_m_tdata[7:6]),
        .o_last  (o_m_tlast)
    );

    // checks
    a_idle_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !w_sts.busy)
        else $error("scan accepted while merge stage still sweeping");

    a_tick_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kars_pkg::ST_TICK) |=> w_sts.busy)
        else $error("lane update not followed by merge sweep");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tlast && (o_m_tdata == 8'd0)
                                           && !o_m_tuser[1]))
        else $error("empty scan beat malformed");

endmodule
